/* hdl/ria_pkg.sv */
// package: shared types and constants of the rate integrator
`default_nettype none

package ria_pkg;

    // number of lane slots carried by one word
    localparam int NUM_LANES = 3;

    // field widths
    localparam int DATA_W  = 24;
    localparam int GAIN_W  = 20;
    localparam int LIMIT_W = 23;
    localparam int CFG_W   = 23;
    localparam int IDX_W   = 3;

    // 1 / radians(400) in unsigned q0.24
    localparam logic [21:0] INV_RAD400_Q24 = 22'd2403159;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_GAIN_ROLL   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN_PITCH  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_YAW    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LIMIT_ROLL  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_LIMIT_PITCH = 3'd4;
    localparam logic [IDX_W-1:0] CFG_LIMIT_YAW   = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RP_RST  = 20'd13107;
    localparam logic [GAIN_W-1:0]  GAIN_Y_RST   = 20'd6554;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 23'd19661;

    typedef logic signed [DATA_W-1:0] t_q816;

    // input word
    typedef struct packed {
        logic signed [DATA_W-1:0] err_roll;
        logic signed [DATA_W-1:0] err_pitch;
        logic signed [DATA_W-1:0] err_yaw;
        logic [DATA_W-1:0]        step_time;
        logic [2:0]               sat_pos_mask;
        logic [2:0]               sat_neg_mask;
    } t_in_item;

    // result word
    typedef struct packed {
        logic signed [DATA_W-1:0] integ_roll;
        logic signed [DATA_W-1:0] integ_pitch;
        logic signed [DATA_W-1:0] integ_yaw;
        logic signed [DATA_W-1:0] clamped_roll;
        logic signed [DATA_W-1:0] clamped_pitch;
        logic signed [DATA_W-1:0] clamped_yaw;
    } t_out_item;

endpackage

`default_nettype wire

/* hdl/ria_if.sv */
// interfaces: valid/ready channels for input and result words
`default_nettype none

interface ria_in_if;
    logic                valid;
    logic                ready;
    ria_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ria_out_if;
    logic                valid;
    logic                ready;
    ria_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/ria_lane.sv */
// lane: one axis of error clamping, gain scheduling and integration
`default_nettype none

module ria_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ria_pkg::t_q816                 i_err,
    input  wire logic                           i_pos,
    input  wire logic                           i_neg,
    input  wire logic [ria_pkg::DATA_W-1:0]     i_dt,
    input  wire logic [ria_pkg::GAIN_W-1:0]     i_gain,
    input  wire logic [ria_pkg::LIMIT_W-1:0]    i_limit,
    input  wire logic                           i_commit,
    output ria_pkg::t_q816                      o_clamped,
    output ria_pkg::t_q816                      o_integ_next
);
    import ria_pkg::*;

    t_q816        w_c;
    logic [23:0]  w_mag;
    t_q816        r_c;
    logic         r_neg;
    logic [23:0]  r_mag;

    logic [45:0]  w_rprod;
    logic [46:0]  w_rsum;
    logic         r_big;
    logic [23:0]  r_r24;

    logic [47:0]  w_rr;
    logic [48:0]  w_f48;
    logic [48:0]  w_fround;
    logic [16:0]  r_f;

    logic [36:0]  r_fg;
    logic [41:0]  r_pp_lo;
    logic [42:0]  r_pp_hi;
    logic [60:0]  w_psum;
    logic [27:0]  r_p;
    logic [51:0]  r_pd;

    logic [52:0]  w_msum;
    logic [28:0]  w_m;
    logic signed [30:0] w_acc;
    logic signed [30:0] w_sum;
    logic signed [30:0] w_lim;
    logic signed [30:0] w_clip;
    t_q816        r_integ;
    t_q816        n_integ;

    // saturation clamp of the error and its magnitude
    always_comb begin
        w_c = i_err;
        if (i_pos && (i_err > 24'sd0)) begin
            w_c = '0;
        end
        if (i_neg && (w_c < 24'sd0)) begin
            w_c = '0;
        end
        w_mag = w_c[23] ? unsigned'(-w_c) : unsigned'(w_c);
    end

    always_ff @(posedge i_clk) begin
        r_c   <= w_c;
        r_neg <= w_c[23];
        r_mag <= w_mag;
    end

    // normalized error r = |c| / radians(400), q.24
    assign w_rprod = 46'(r_mag) * 46'(INV_RAD400_Q24);
    assign w_rsum  = {1'b0, w_rprod} + 47'd32768;

    always_ff @(posedge i_clk) begin
        r_big <= |w_rsum[46:40];
        r_r24 <= w_rsum[39:16];
    end

    // gain factor f = 1 - r^2, q1.16
    assign w_rr     = 48'(r_r24) * 48'(r_r24);
    assign w_f48    = r_big ? 49'd0 : ({1'b1, 48'd0} - {1'b0, w_rr});
    assign w_fround = w_f48 + 49'h0_0000_8000_0000;

    always_ff @(posedge i_clk) begin
        r_f <= w_fround[48:32];
    end

    // scaled gain, then the product with |c| in two partial products
    always_ff @(posedge i_clk) begin
        r_fg    <= 37'(r_f) * 37'(i_gain);
        r_pp_lo <= 42'(r_fg[17:0]) * 42'(r_mag);
        r_pp_hi <= 43'(r_fg[36:18]) * 43'(r_mag);
    end

    assign w_psum = {r_pp_hi, 18'd0} + 61'(r_pp_lo) + 61'h0_8000_0000;

    always_ff @(posedge i_clk) begin
        r_p  <= w_psum[59:32];
        r_pd <= 52'(r_p) * 52'(i_dt);
    end

    // increment, accumulate and clamp to the limit
    assign w_msum = {1'b0, r_pd} + 53'h80_0000;
    assign w_m    = w_msum[52:24];
    assign w_acc  = {{7{r_integ[23]}}, r_integ};
    assign w_lim  = {8'd0, i_limit};
    assign w_sum  = r_neg ? (w_acc - $signed({2'b00, w_m}))
                          : (w_acc + $signed({2'b00, w_m}));

    always_comb begin
        w_clip = w_sum;
        if (w_sum > w_lim) begin
            w_clip = w_lim;
        end else if (w_sum < -w_lim) begin
            w_clip = -w_lim;
        end
        n_integ = w_clip[23:0];
    end

    // integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_commit) begin
            r_integ <= n_integ;
        end
    end

    assign o_clamped    = r_c;
    assign o_integ_next = n_integ;

endmodule

`default_nettype wire

/* hdl/ria_merge.sv */
// merge stage: collects the lane results into the output word register
`default_nettype none

module ria_merge (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_commit,
    input  wire ria_pkg::t_q816  i_integ   [ria_pkg::NUM_LANES],
    input  wire ria_pkg::t_q816  i_clamped [ria_pkg::NUM_LANES],
    output logic                 o_free,
    ria_out_if.source            o_out
);
    import ria_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // output slot can take a word this cycle
    assign o_free = !r_valid || o_out.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_item.integ_roll    <= i_integ[0];
            r_item.integ_pitch   <= i_integ[1];
            r_item.integ_yaw     <= i_integ[2];
            r_item.clamped_roll  <= i_clamped[0];
            r_item.clamped_pitch <= i_clamped[1];
            r_item.clamped_yaw   <= i_clamped[2];
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

endmodule

`default_nettype wire

/* hdl/rate_integrator_anti_windup_top.sv */
// top level: three-axis rate integrator with anti-windup
//
// Each input word carries roll, pitch and yaw rate errors, a time step and
// per-axis saturation flags; each returns one result word with the updated
// integrators and the clamped errors. The axes run in parallel lanes, each a
// seven-register multiply chain (normalization, gain factor, gain, error,
// time step); a word commits once the chain has settled, and the block takes
// no new word until then. The result sits in an output register, so the next
// word is accepted while the previous result waits; a commit stalls only if
// that register is still full. The user must write configuration registers
// only while idle; the block does not check this. Indexes above five are ignored.
`default_nettype none

module rate_integrator_anti_windup_top #(
    parameter int AXES = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ria_in_if.sink                             i_in,
    ria_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ria_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ria_pkg::CFG_W-1:0]     i_cfg_data
);
    import ria_pkg::*;

    localparam logic [2:0] CNT_LAST = 3'd7;

    logic [GAIN_W-1:0]  r_gain  [NUM_LANES];
    logic [LIMIT_W-1:0] r_limit [NUM_LANES];
    t_in_item           r_item;
    logic               r_busy;
    logic [2:0]         r_cnt;
    logic               w_accept;
    logic               w_commit;
    logic               w_free;
    t_q816              w_err     [NUM_LANES];
    t_q816              w_integ   [NUM_LANES];
    t_q816              w_clamped [NUM_LANES];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0]  <= GAIN_RP_RST;
            r_gain[1]  <= GAIN_RP_RST;
            r_gain[2]  <= GAIN_Y_RST;
            r_limit[0] <= LIMIT_RST;
            r_limit[1] <= LIMIT_RST;
            r_limit[2] <= LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_ROLL:   r_gain[0]  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_PITCH:  r_gain[1]  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_YAW:    r_gain[2]  <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT_ROLL:  r_limit[0] <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_PITCH: r_limit[1] <= i_cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_YAW:   r_limit[2] <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake and sequencing
    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;
    assign w_commit   = r_busy && (r_cnt == CNT_LAST) && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_commit) begin
            r_busy <= 1'b0;
        end else if (r_busy && (r_cnt != CNT_LAST)) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    // input word held for the lanes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in.data;
        end
    end

    assign w_err[0] = r_item.err_roll;
    assign w_err[1] = r_item.err_pitch;
    assign w_err[2] = r_item.err_yaw;

    // axis lanes
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        if (g < AXES) begin : g_on
            ria_lane u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_err        (w_err[g]),
                .i_pos        (r_item.sat_pos_mask[g]),
                .i_neg        (r_item.sat_neg_mask[g]),
                .i_dt         (r_item.step_time),
                .i_gain       (r_gain[g]),
                .i_limit      (r_limit[g]),
                .i_commit     (w_commit),
                .o_clamped    (w_clamped[g]),
                .o_integ_next (w_integ[g])
            );
        end else begin : g_off
            assign w_clamped[g] = '0;
            assign w_integ[g]   = '0;
        end
    end

    // merge into the output register
    ria_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (w_commit),
        .i_integ   (w_integ),
        .i_clamped (w_clamped),
        .o_free    (w_free),
        .o_out     (o_out)
    );

    // a word commits only after the full chain has settled
    a_commit_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (r_cnt == CNT_LAST))
        else $error("commit before the lane chain settled");

    // an accepted word restarts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_busy && (r_cnt == 3'd0)))
        else $error("sequencer not started by accepted word");

    // every commit presents a result word
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out.valid)
        else $error("commit without result word");

    // a word in flight is not dropped before its commit
    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt != CNT_LAST)) |=> r_busy)
        else $error("word dropped before commit");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// testbench: three-axis rate integrator checked word by word against a local model
`timescale 1ns / 1ps

module tb_top;
    import ria_pkg::*;

    localparam int AXES        = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 240;
    localparam int MAX_WAIT    = 17;
    // radians(400) in q8.16, where the gain factor reaches zero
    localparam int RAD400_Q16  = 457527;

    // indexes past the register file, writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    ria_in_if  in_ch ();
    ria_out_if out_ch ();

    rate_integrator_anti_windup_top #(
        .AXES(AXES)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    // rate words waiting to be sent and result words still owed by the block
    t_in_item  rate_words[$];
    t_out_item owed_results[$];

    // local copy of the registers and integrators
    logic [GAIN_W-1:0]  gain_reg[3];
    logic [LIMIT_W-1:0] limit_reg[3];
    longint             integ_acc[3];

    int  words_queued;
    int  words_accepted;
    int  words_checked;
    int  fail_count;
    int  limit_hits;
    int  error_clamps;
    int  settings_used;
    int  cycle_count;
    int  send_wait;
    int  recv_wait;
    bit  pace_gaps;

    // clock
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // one axis: gain factor, scaled increment, clamp to the limit
    function automatic longint step_axis(longint acc, longint c, longint unsigned dt,
                                         longint unsigned gain, longint unsigned lim);
        longint unsigned mag;
        longint unsigned r;
        longint unsigned rr;
        longint unsigned f48;
        longint unsigned f;
        longint unsigned p;
        longint unsigned m;
        longint unsigned one48;
        longint          sum;
        one48 = 64'd1 << 48;
        mag = (c < 0) ? -c : c;
        r = (mag * INV_RAD400_Q24 + (64'd1 << 15)) >> 16;
        rr = r * r;
        f48 = (rr >= one48) ? 64'd0 : one48 - rr;
        f = (f48 + (64'd1 << 31)) >> 32;
        p = (f * gain * mag + (64'd1 << 31)) >> 32;
        m = (p * dt + (64'd1 << 23)) >> 24;
        sum = (c < 0) ? acc - longint'(m) : acc + longint'(m);
        if (sum > longint'(lim)) sum = longint'(lim);
        if (sum < -longint'(lim)) sum = -longint'(lim);
        return sum;
    endfunction

    // update the integrators for one rate word and build its result word
    function automatic t_out_item integrate_word(t_in_item w);
        longint    err[3];
        longint    c;
        logic [DATA_W-1:0] integ_v[3];
        logic [DATA_W-1:0] clamp_v[3];
        t_out_item res;
        err[0] = longint'($signed(w.err_roll));
        err[1] = longint'($signed(w.err_pitch));
        err[2] = longint'($signed(w.err_yaw));
        for (int a = 0; a < 3; a++) begin
            c = 0;
            if (a < AXES) begin
                c = err[a];
                if (w.sat_pos_mask[a] && c > 0) c = 0;
                if (w.sat_neg_mask[a] && c < 0) c = 0;
                if (c != err[a]) error_clamps++;
                integ_acc[a] = step_axis(integ_acc[a], c, 64'(w.step_time),
                                         64'(gain_reg[a]), 64'(limit_reg[a]));
                if (limit_reg[a] != 0 &&
                    (integ_acc[a] == limit_reg[a] || integ_acc[a] == -longint'(limit_reg[a])))
                    limit_hits++;
            end
            integ_v[a] = integ_acc[a][DATA_W-1:0];
            clamp_v[a] = c[DATA_W-1:0];
        end
        res.integ_roll    = integ_v[0];
        res.integ_pitch   = integ_v[1];
        res.integ_yaw     = integ_v[2];
        res.clamped_roll  = clamp_v[0];
        res.clamped_pitch = clamp_v[1];
        res.clamped_yaw   = clamp_v[2];
        return res;
    endfunction

    task automatic check_field(string name, logic signed [DATA_W-1:0] want,
                               logic signed [DATA_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // sender: pops rate words, random gap after each accepted word while pace_gaps is set
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_wait = 0;
        end else begin
            next_valid = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                next_valid = 1'b0;
                send_wait = pace_gaps ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (!next_valid) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (rate_words.size() > 0) begin
                    in_ch.data <= rate_words.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // receiver: random stall after each accepted result word while pace_gaps is set
    always @(posedge i_clk) begin
        logic next_ready;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            next_ready = out_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                recv_wait = pace_gaps ? $urandom_range(0, MAX_WAIT) : 0;
                if (recv_wait > 0) next_ready = 1'b0;
            end else if (!out_ch.ready) begin
                if (recv_wait > 0) recv_wait--;
                if (recv_wait == 0) next_ready = 1'b1;
            end
            out_ch.ready <= next_ready;
        end
    end

    // monitor: register mirror, result check, prediction on accepted words
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            gain_reg[0] = GAIN_RP_RST;
            gain_reg[1] = GAIN_RP_RST;
            gain_reg[2] = GAIN_Y_RST;
            for (int a = 0; a < 3; a++) begin
                limit_reg[a] = LIMIT_RST;
                integ_acc[a] = 0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_GAIN_ROLL:   gain_reg[0] = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_PITCH:  gain_reg[1] = cfg_data[GAIN_W-1:0];
                    CFG_GAIN_YAW:    gain_reg[2] = cfg_data[GAIN_W-1:0];
                    CFG_LIMIT_ROLL:  limit_reg[0] = cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT_PITCH: limit_reg[1] = cfg_data[LIMIT_W-1:0];
                    CFG_LIMIT_YAW:   limit_reg[2] = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    $error("result word with no expected word pending");
                end else begin
                    want = owed_results.pop_front();
                    words_checked++;
                    check_field("integ_roll", want.integ_roll, out_ch.data.integ_roll);
                    check_field("integ_pitch", want.integ_pitch, out_ch.data.integ_pitch);
                    check_field("integ_yaw", want.integ_yaw, out_ch.data.integ_yaw);
                    check_field("clamped_roll", want.clamped_roll, out_ch.data.clamped_roll);
                    check_field("clamped_pitch", want.clamped_pitch,
                                out_ch.data.clamped_pitch);
                    check_field("clamped_yaw", want.clamped_yaw, out_ch.data.clamped_yaw);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                owed_results.push_back(integrate_word(in_ch.data));
                words_accepted++;
            end
        end
    end

    // field values arrive as plain integers, the low bits are the word bits
    task automatic queue_word(int er, int ep, int ey, int dt,
                              logic [2:0] pos, logic [2:0] neg);
        t_in_item w;
        w.err_roll     = er[DATA_W-1:0];
        w.err_pitch    = ep[DATA_W-1:0];
        w.err_yaw      = ey[DATA_W-1:0];
        w.step_time    = dt[DATA_W-1:0];
        w.sat_pos_mask = pos;
        w.sat_neg_mask = neg;
        rate_words.push_back(w);
        words_queued++;
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic load_registers(logic [CFG_W-1:0] g0, logic [CFG_W-1:0] g1,
                                  logic [CFG_W-1:0] g2, logic [CFG_W-1:0] l0,
                                  logic [CFG_W-1:0] l1, logic [CFG_W-1:0] l2);
        cfg_write(CFG_GAIN_ROLL, g0);
        cfg_write(CFG_GAIN_PITCH, g1);
        cfg_write(CFG_GAIN_YAW, g2);
        cfg_write(CFG_LIMIT_ROLL, l0);
        cfg_write(CFG_LIMIT_PITCH, l1);
        cfg_write(CFG_LIMIT_YAW, l2);
    endtask

    // block drained: every word taken and every result returned
    task automatic wait_idle();
        do @(negedge i_clk);
        while (words_accepted != words_queued || owed_results.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // mostly errors near the factor cutoff, some full range and extremes
    function automatic int rand_err();
        int v;
        int mag;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                mag = $urandom_range(0, RAD400_Q16 + 12000);
                v = $urandom_range(0, 1) ? -mag : mag;
            end
            6, 7: v = int'($urandom());
            8: begin
                case ($urandom_range(0, 3))
                    0: v = 8388607;
                    1: v = -8388608;
                    2: v = -1;
                    default: v = 1;
                endcase
            end
            default: begin
                mag = $urandom_range(0, 300);
                v = $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
        return v;
    endfunction

    function automatic int rand_step();
        case ($urandom_range(0, 8))
            6: return 32'h00FFFFFF;
            7: return 0;
            8: return int'($urandom_range(0, 65535));
            default: return int'($urandom());
        endcase
    endfunction

    function automatic logic [2:0] rand_mask();
        return $urandom_range(0, 1) ? 3'b000 : 3'($urandom());
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(0, 70000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_limit_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(1, 200000));
        endcase
    endfunction

    // stimulus and end of run
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        pace_gaps    = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset register values
        settings_used = 1;
        queue_word(0, 0, 0, 0, 3'b000, 3'b000);
        queue_word(65536, -65536, 32768, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(65536, -65536, 32768, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(65536, -65536, 32768, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(32'h007FFFFF, 32'h00800000, 1, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(RAD400_Q16, -(RAD400_Q16 + 1), RAD400_Q16 - 1000, 32'h00FFFFFF,
                   3'b000, 3'b000);
        queue_word(100000, -100000, 32'h007FFFFF, 32'h00FFFFFF, 3'b111, 3'b111);
        queue_word(100000, -100000, 50000, 32'h00FFFFFF, 3'b111, 3'b000);
        queue_word(100000, -100000, -50000, 32'h00FFFFFF, 3'b000, 3'b111);
        queue_word(-200000, 200000, 200000, 32'h00800000, 3'b101, 3'b010);
        queue_word(200000, -200000, -200000, 32'h00800000, 3'b010, 3'b101);
        queue_word(-300000, -300000, -300000, 0, 3'b000, 3'b000);
        queue_word(-1, 1, -1, 1, 3'b000, 3'b000);
        queue_word(-196608, -196608, -196608, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(-196608, -196608, -196608, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(-196608, -196608, -196608, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(0, 0, 0, 32'h00FFFFFF, 3'b000, 3'b000);
        queue_word(32'h00800000, 32'h007FFFFF, 32'h00800000, 32'h00FFFFFF, 3'b111, 3'b000);
        queue_word(32'h00800000, 32'h007FFFFF, 32'h00800000, 32'h00FFFFFF, 3'b000, 3'b111);
        queue_word(32'h00555555, 32'h00AAAAAA, 32'h000F0F0F, 32'h00555555, 3'b000, 3'b000);
        queue_word(32'h00AAAAAA, 32'h00555555, 32'h00F0F0F0, 32'h00AAAAAA, 3'b000, 3'b000);
        queue_word(RAD400_Q16 - 1, -(RAD400_Q16 - 1), 400000, 32'h00FFFFFF,
                   3'b000, 3'b000);
        wait_idle();

        // random phases, each on its own register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: load_registers('1, '1, '1, '1, '1, '1);
                1: begin
                    load_registers('0, '0, '0, rand_limit_word(), rand_limit_word(),
                                   rand_limit_word());
                    cfg_write(CFG_SPARE_LO, CFG_W'($urandom()));
                    cfg_write(CFG_SPARE_HI, CFG_W'($urandom()));
                end
                2: load_registers(rand_gain_word(), rand_gain_word(), rand_gain_word(),
                                  '0, '0, '0);
                default: load_registers(rand_gain_word(), rand_gain_word(), rand_gain_word(),
                                        rand_limit_word(), rand_limit_word(),
                                        rand_limit_word());
            endcase
            settings_used++;
            // some phases run back to back with no gaps or stalls
            pace_gaps = !(p == 1 || p == 5);
            for (int k = 0; k < PHASE_WORDS; k++)
                queue_word(rand_err(), rand_err(), rand_err(), rand_step(), rand_mask(),
                           rand_mask());
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        $display("checked %0d result words from %0d rate words over %0d register settings",
                 words_checked, words_accepted, settings_used);
        $display("%0d axis updates ended on the limit, %0d errors clamped by saturation flags",
                 limit_hits, error_clamps);
        if (fail_count == 0) begin
            $display("PASS rate_integrator_anti_windup_top");
        end else begin
            $display("FAIL rate_integrator_anti_windup_top");
        end
        $finish;
    end

    // watchdog
    initial begin
        cycle_count    = 0;
        words_queued   = 0;
        words_accepted = 0;
        words_checked  = 0;
        fail_count     = 0;
        limit_hits     = 0;
        error_clamps   = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped after %0d cycles", CYCLE_LIMIT);
        $display("FAIL rate_integrator_anti_windup_top");
        $finish;
    end

endmodule

/* sim.f */
hdl/ria_pkg.sv
hdl/ria_if.sv
hdl/ria_lane.sv
hdl/ria_merge.sv
hdl/rate_integrator_anti_windup_top.sv
sim/tb_top.sv
